@@ design/ucdp_pkg.sv @@
// shared types and constants of the configuration descriptor parser
package ucdp_pkg;

	localparam int unsigned HdrLen   = 9;
	localparam int unsigned MaxRecs  = 4;
	localparam int unsigned MTdataW  = 96;

	localparam logic [7:0] DtConfig    = 8'h02;
	localparam logic [7:0] DtInterface = 8'h04;
	localparam logic [7:0] DtEndpoint  = 8'h05;
	localparam logic [7:0] DtHid       = 8'h21;
	localparam logic [7:0] DtHidReport = 8'h22;
	localparam logic [7:0] IfMinLen    = 8'd9;
	localparam logic [7:0] EpMinLen    = 8'd7;
	localparam logic [7:0] DescMinLen  = 8'd2;
	localparam logic [7:0] EpAddrRsvd  = 8'h70;

	// record kinds carried on tuser
	localparam logic [1:0] KindHeader    = 2'd0;
	localparam logic [1:0] KindInterface = 2'd1;
	localparam logic [1:0] KindEndpoint  = 2'd2;
	localparam logic [1:0] KindStatus    = 2'd3;

	// status codes
	localparam logic [7:0] StOk       = 8'd0;
	localparam logic [7:0] StHeader   = 8'd1;
	localparam logic [7:0] StLength   = 8'd2;
	localparam logic [7:0] StChain    = 8'd3;
	localparam logic [7:0] StCapacity = 8'd4;

	// configuration register indexes
	localparam logic CfgIfCap = 1'b0;
	localparam logic CfgEpCap = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  id;
		logic [7:0]  attr;
		logic [7:0]  cls;
		logic [7:0]  sub;
		logic [7:0]  proto;
		logic [7:0]  aux;
		logic [7:0]  tally;
		logic        hid;
		logic [15:0] wa;
		logic [15:0] wb;
	} rec_t;

	typedef struct packed {
		logic [7:0]  num;
		logic [7:0]  alt;
		logic [7:0]  cls;
		logic [7:0]  sub;
		logic [7:0]  proto;
		logic [7:0]  country;
		logic [7:0]  tally;
		logic        hid;
		logic [15:0] ver;
		logic [15:0] rlen;
	} iface_t;

	// handoff from the parser to the record buffer
	typedef struct packed {
		logic       load;
		logic [2:0] cnt;
	} load_t;

	function automatic rec_t iface_rec(input iface_t oi);
		rec_t r;
		r       = '0;
		r.kind  = KindInterface;
		r.id    = oi.num;
		r.attr  = oi.alt;
		r.cls   = oi.cls;
		r.sub   = oi.sub;
		r.proto = oi.proto;
		r.aux   = oi.country;
		r.tally = oi.tally;
		r.hid   = oi.hid;
		r.wa    = oi.ver;
		r.wb    = oi.rlen;
		return r;
	endfunction

endpackage

@@ design/ucdp_parse.sv @@
// input register, descriptor walk and per-byte record generation
module ucdp_parse import ucdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        can_load,
	output load_t       ld,
	output rec_t        recs [MaxRecs]
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	logic [15:0] if_cap_q, ep_cap_q;
	logic [15:0] pos_q, decl_q, start_q, itot_q, etot_q;
	logic        have_q, cerr_q, wd_q;
	iface_t      oi_q;
	logic [7:0]  hb_q [HdrLen];
	logic [7:0]  dq   [HdrLen];

	logic [15:0] pos_n, decl_n, start_n, itot_n, etot_n;
	logic        have_n, cerr_n, wd_n;
	iface_t      oi_n;
	logic        d_we;
	logic [15:0] rel, total;
	logic [7:0]  hv [HdrLen];
	logic [7:0]  dv [HdrLen];
	logic [7:0]  b, size, dtype, status;
	logic [16:0] endsum;
	logic [15:0] htotal;
	logic        ok;
	logic [2:0]  n;
	rec_t        hrec, srec, erec;
	logic        proc;

	assign proc     = valid_s1 && (can_load || (n == 3'd0));
	assign s_tready = !valid_s1 || proc;
	assign ld.load  = proc && (n != 3'd0);
	assign ld.cnt   = n;

	// walk of one byte
	always_comb begin
		b       = data_s1;
		pos_n   = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
		decl_n  = decl_q;
		start_n = start_q;
		itot_n  = itot_q;
		etot_n  = etot_q;
		have_n  = have_q;
		cerr_n  = cerr_q;
		wd_n    = wd_q;
		oi_n    = oi_q;
		d_we    = 1'b0;
		n       = 3'd0;
		for (int i = 0; i < MaxRecs; i++) recs[i] = '0;
		rel = pos_q - start_q;
		for (int i = 0; i < HdrLen; i++) begin
			hv[i] = (pos_q == 16'(i)) ? b : ((pos_q > 16'(i)) ? hb_q[i] : 8'd0);
			dv[i] = (rel == 16'(i)) ? b : dq[i];
		end
		size   = dv[0];
		dtype  = dv[1];
		endsum = {1'b0, start_q} + {9'd0, size};
		total  = decl_q;
		ok     = !wd_q;
		erec   = '0;
		hrec   = '0;
		srec   = '0;
		status = StOk;
		htotal = {hv[3], hv[2]};

		// header checks
		if (ok && pos_q == 16'd0 && b < 8'd9) begin
			wd_n = 1'b1; ok = 1'b0;
		end
		if (ok && pos_q == 16'd1 && b != DtConfig) begin
			wd_n = 1'b1; ok = 1'b0;
		end
		if (ok && pos_q == 16'd3) begin
			total  = {b, hb_q[2]};
			decl_n = total;
			if (total < 16'd9) begin
				wd_n = 1'b1; ok = 1'b0;
			end else if ({8'd0, hb_q[0]} > total) begin
				cerr_n = 1'b1; wd_n = 1'b1; ok = 1'b0;
			end
		end
		if (ok && pos_q >= 16'd4 && pos_q >= total) begin
			wd_n = 1'b1; ok = 1'b0;
		end
		if (ok && pos_q < start_q) begin
			wd_n = 1'b1; ok = 1'b0;
		end

		// descriptor body
		if (ok) begin
			d_we = (rel < 16'(HdrLen));
			if (rel == 16'd0) begin
				if (start_q != 16'd0 &&
				    (({1'b0, start_q} + 17'd2 > {1'b0, total}) || size < DescMinLen ||
				     {8'd0, size} > total - start_q)) begin
					cerr_n = 1'b1; wd_n = 1'b1;
				end
			end else begin
				if (rel == 16'd1) begin
					if ((dtype == DtInterface && size < IfMinLen) ||
					    (dtype == DtHid && (size < IfMinLen || !have_q)) ||
					    (dtype == DtEndpoint && (size < EpMinLen || !have_q))) begin
						cerr_n = 1'b1; wd_n = 1'b1; ok = 1'b0;
					end
				end
				if (ok && dtype == DtHid &&
				    ((rel == 16'd5 && b == 8'd0) || (rel == 16'd6 && b != DtHidReport))) begin
					cerr_n = 1'b1; wd_n = 1'b1; ok = 1'b0;
				end
				if (ok && dtype == DtEndpoint && rel == 16'd2 && (b & EpAddrRsvd) != 8'd0) begin
					cerr_n = 1'b1; wd_n = 1'b1; ok = 1'b0;
				end
				if (ok && ({1'b0, rel} + 17'd1 == {9'd0, size})) begin
					if (dtype == DtInterface) begin
						if (have_q) begin
							recs[n[1:0]] = iface_rec(oi_q);
							n = n + 3'd1;
						end
						oi_n       = '0;
						oi_n.num   = dv[2];
						oi_n.alt   = dv[3];
						oi_n.cls   = dv[5];
						oi_n.sub   = dv[6];
						oi_n.proto = dv[7];
						have_n     = 1'b1;
						itot_n     = itot_q + 16'd1;
					end else if (dtype == DtHid) begin
						if (!oi_q.hid) begin
							oi_n.country = dv[4];
							oi_n.hid     = 1'b1;
							oi_n.ver     = {dv[3], dv[2]};
							oi_n.rlen    = {dv[8], dv[7]};
						end
					end else if (dtype == DtEndpoint) begin
						erec.kind    = KindEndpoint;
						erec.id      = dv[2];
						erec.attr    = dv[3];
						erec.wa      = {dv[5], dv[4]};
						erec.aux     = dv[6];
						recs[n[1:0]] = erec;
						n            = n + 3'd1;
						etot_n       = etot_q + 16'd1;
						oi_n.tally   = oi_q.tally + 8'd1;
					end
					start_n = endsum[15:0];
					// walk reaches the declared total
					if (endsum >= {1'b0, total}) begin
						wd_n = 1'b1;
						if (have_n) begin
							recs[n[1:0]] = iface_rec(oi_n);
							n            = n + 3'd1;
							have_n       = 1'b0;
						end
					end
				end
			end
		end

		// buffer end: header and status, then rearm
		if (last_s1) begin
			hrec.kind = KindHeader;
			hrec.id   = hv[5];
			hrec.attr = hv[7];
			hrec.cls  = hv[4];
			hrec.sub  = hv[8];
			hrec.wa   = htotal;
			if (pos_n < 16'd9 || hv[0] < 8'd9 || hv[1] != DtConfig)
				status = StHeader;
			else if (htotal < 16'd9 || htotal > pos_n)
				status = StLength;
			else if (cerr_n)
				status = StChain;
			else if (itot_n > if_cap_q || etot_n > ep_cap_q)
				status = StCapacity;
			else
				status = StOk;
			srec.kind    = KindStatus;
			srec.id      = status;
			srec.wa      = itot_n;
			srec.wb      = etot_n;
			recs[n[1:0]] = hrec;
			n            = n + 3'd1;
			recs[n[1:0]] = srec;
			n            = n + 3'd1;
			pos_n   = '0;
			decl_n  = '0;
			start_n = '0;
			oi_n    = '0;
			have_n  = 1'b0;
			itot_n  = '0;
			etot_n  = '0;
			cerr_n  = 1'b0;
			wd_n    = 1'b0;
		end
	end

	// input register and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			if_cap_q <= 16'hFFFF;
			ep_cap_q <= 16'hFFFF;
			pos_q    <= '0;
			decl_q   <= '0;
			start_q  <= '0;
			itot_q   <= '0;
			etot_q   <= '0;
			have_q   <= 1'b0;
			cerr_q   <= 1'b0;
			wd_q     <= 1'b0;
			oi_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CfgIfCap) if_cap_q <= cfg_data;
				if (cfg_index == CfgEpCap) ep_cap_q <= cfg_data;
			end
			if (s_tready) valid_s1 <= s_tvalid;
			if (proc) begin
				pos_q   <= pos_n;
				decl_q  <= decl_n;
				start_q <= start_n;
				itot_q  <= itot_n;
				etot_q  <= etot_n;
				have_q  <= have_n;
				cerr_q  <= cerr_n;
				wd_q    <= wd_n;
				oi_q    <= oi_n;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (proc && pos_q < 16'(HdrLen)) hb_q[pos_q[3:0]] <= b;
		if (proc && d_we) dq[rel[3:0]] <= b;
	end

endmodule

@@ design/ucdp_outbuf.sv @@
// record buffer that drains the records of one byte, one word per cycle while m_tready is high
module ucdp_outbuf import ucdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  load_t      ld,
	input  rec_t       recs [MaxRecs],
	output logic       can_load,
	output logic       m_tvalid,
	input  logic       m_tready,
	output rec_t       head_rec,
	output logic       m_tlast
);

	rec_t       slot_q [MaxRecs];
	logic [2:0] rem_q;
	logic [1:0] head_q;
	logic       pop;

	assign m_tvalid = (rem_q != 3'd0);
	assign pop      = m_tvalid && m_tready;
	assign can_load = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);
	assign head_rec = slot_q[head_q];
	assign m_tlast  = (rem_q == 3'd1);

	// count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			head_q <= '0;
		end else if (ld.load) begin
			rem_q  <= ld.cnt;
			head_q <= '0;
		end else if (pop) begin
			rem_q  <= rem_q - 3'd1;
			head_q <= head_q + 2'd1;
		end
	end

	// record slots
	always_ff @(posedge clk) begin
		if (ld.load) begin
			for (int i = 0; i < MaxRecs; i++) slot_q[i] <= recs[i];
		end
	end

endmodule

@@ design/usb_config_descriptor_parser_top.sv @@
// top level of the usb configuration descriptor parser
//
// channel  dir  tdata                       tuser         tlast
// s_*      in   data byte                   -             end of buffer
// m_*      out  record fields (96 bits)     record kind   last record of a byte
// cfg_*    in   capacity write: index 0 interfaces, 1 endpoints
//
// one byte per cycle enters the input register while s_tready is high; the walk is
// combinational from there into the registers of the record buffer.
// the buffer drains one word per cycle while m_tready is high; a later byte with
// records waits in the input register until the last buffered word leaves; bytes
// with no record flow at one per cycle.
// reset clears the walk, the counts and the buffer; capacities reset to 65535.
module usb_config_descriptor_parser_top import ucdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	// id[7:0] attr[15:8] class[23:16] subclass[31:24] protocol[39:32]
	// aux[47:40] endpoint_tally[55:48] hid_present[56] word_a[72:57] word_b[88:73]
	output logic [MTdataW-1:0] m_tdata,
	output logic [1:0]         m_tuser,   // record_kind
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	load_t ld;
	rec_t  recs [MaxRecs];
	rec_t  head_rec;
	logic  can_load;

	ucdp_parse u_parse (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.cfg_we, .cfg_index, .cfg_data, .can_load, .ld, .recs
	);

	ucdp_outbuf u_outbuf (
		.clk, .arst_n, .ld, .recs, .can_load, .m_tvalid, .m_tready,
		.head_rec, .m_tlast
	);

	// pack the record word
	assign m_tuser = head_rec.kind;
	assign m_tdata = {7'd0, head_rec.wb, head_rec.wa, head_rec.hid, head_rec.tally,
	                  head_rec.aux, head_rec.proto, head_rec.sub, head_rec.cls,
	                  head_rec.attr, head_rec.id};

endmodule

@@ design/ucdp_checker.sv @@
// port checks for the parser, bound to the top level
module ucdp_checker import ucdp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [MTdataW-1:0] m_tdata,
	input logic [1:0]         m_tuser,
	input logic               m_tlast
);

	// a stalled record word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed under stall");

	// status closes the records of a byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KindStatus |-> m_tlast)
		else $error("status word without tlast");

	// header never ends a byte's records
	a_header_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KindHeader |-> !m_tlast)
		else $error("header word with tlast");

	// header is followed at once by status
	a_header_then_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == KindHeader |=> m_tvalid && m_tuser == KindStatus)
		else $error("header word not followed by status");

endmodule

bind usb_config_descriptor_parser_top ucdp_checker u_ucdp_checker (
	.clk, .arst_n, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
